>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked assertions with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in the same cycle as the trigger.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
		else $error(msg);

// Condition in the cycle after the trigger.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> sv/tgadec_pkg.sv
// ----------------------------------------------------------------------------
// tgadec_pkg
// Shared codes, constants and the command word of the TGA stream decoder.
// ----------------------------------------------------------------------------
package tgadec_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [7:0] RLE_IMAGE_TYPE = 8'd10;
	localparam logic [7:0] DEPTH_16       = 8'd16;
	localparam logic [7:0] DEPTH_24       = 8'd24;
	localparam logic [7:0] DEPTH_32       = 8'd32;

	localparam logic [2:0] CHAN_RGB  = 3'd3;
	localparam logic [2:0] CHAN_RGBA = 3'd4;

	localparam int QUEUE_DEPTH = 2;

	// One classified result on its way from the parser to the output stage
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pix_word;   // file bytes of the pixel, first byte lowest
		logic        fmt16;      // 5-5-5 packed pixel
		logic        has_alpha;
		logic [7:0]  repeat_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  channels;
		logic        last;
	} cmd_t;

endpackage

>>> sv/tgadec_if.sv
// ----------------------------------------------------------------------------
// tgadec_if
// Valid/ready channels of the TGA stream decoder: file bytes in, results out.
// ----------------------------------------------------------------------------
interface tgadec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, data_byte, file_start, input ready);
	modport sink (input valid, data_byte, file_start, output ready);
endinterface

interface tgadec_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_count;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [2:0]  channels;
	logic        last;

	modport source (output valid, kind, red, green, blue, alpha, repeat_count,
		image_width, image_height, channels, last, input ready);
	modport sink (input valid, kind, red, green, blue, alpha, repeat_count,
		image_width, image_height, channels, last, output ready);
endinterface

>>> sv/tgadec_front.sv
// ----------------------------------------------------------------------------
// tgadec_front
// Byte parser: header fields, ID skip, RLE packet headers and pixel assembly.
// ----------------------------------------------------------------------------
module tgadec_front import tgadec_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	tgadec_in_if.sink      byte_stream,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output cmd_t           cmd
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_PACKET = 3'd2;
	localparam logic [2:0] PH_PIXEL  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  hdr_pos_q, hdr_pos_d;
	logic [7:0]  id_len_q, id_len_d;
	logic        rle_q, rle_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  depth_q, depth_d;
	logic [31:0] area_q, area_d;
	logic [7:0]  skip_q, skip_d;
	logic [31:0] pix_rem_q, pix_rem_d;
	logic [7:0]  pkt_rem_q, pkt_rem_d;
	logic        pkt_rep_q, pkt_rep_d;
	logic [1:0]  bip_q, bip_d;
	logic [23:0] pix_bytes_q, pix_bytes_d;

	logic        take;
	logic [7:0]  b;
	logic [2:0]  phase_c;
	logic [4:0]  pos_c;
	logic [15:0] width_c;
	logic [15:0] height_c;
	logic [2:0]  chan;
	logic [1:0]  need;
	logic [1:0]  bip_next;
	logic [31:0] word;
	logic [7:0]  rep;
	logic [31:0] rem_after;
	logic [7:0]  pkt_after;

	assign byte_stream.ready = cmd_ready;
	assign take = byte_stream.valid && cmd_ready;
	assign b    = byte_stream.data_byte;
	assign chan = (depth_q == DEPTH_32) ? CHAN_RGBA : CHAN_RGB;
	assign need = depth_q[4:3];
	assign bip_next = bip_q + 2'd1;
	assign word = {8'h00, pix_bytes_q} | ({24'h0, b} << {bip_q, 3'b000});

	// run clipping and the pixel count that follows this pixel
	always_comb begin
		pkt_after = pkt_rem_q;
		rep = 8'd1;
		if (rle_q) begin
			if (pkt_rep_q) begin
				rep = (pix_rem_q < {24'h0, pkt_rem_q}) ? pix_rem_q[7:0] : pkt_rem_q;
				pkt_after = 8'd0;
			end else if (pkt_rem_q != 8'd0) begin
				pkt_after = pkt_rem_q - 8'd1;
			end
		end
		rem_after = pix_rem_q - {24'h0, rep};
	end

	always_comb begin
		phase_d     = phase_q;
		hdr_pos_d   = hdr_pos_q;
		id_len_d    = id_len_q;
		rle_d       = rle_q;
		width_d     = width_q;
		height_d    = height_q;
		depth_d     = depth_q;
		area_d      = area_q;
		skip_d      = skip_q;
		pix_rem_d   = pix_rem_q;
		pkt_rem_d   = pkt_rem_q;
		pkt_rep_d   = pkt_rep_q;
		bip_d       = bip_q;
		pix_bytes_d = pix_bytes_q;
		cmd_valid   = 1'b0;
		cmd              = '0;
		cmd.image_width  = width_q;
		cmd.image_height = height_q;

		// a new file restarts the header walk on this very word
		phase_c  = byte_stream.file_start ? PH_HEADER : phase_q;
		pos_c    = byte_stream.file_start ? 5'd0 : hdr_pos_q;
		width_c  = byte_stream.file_start ? 16'h0 : width_q;
		height_c = byte_stream.file_start ? 16'h0 : height_q;

		if (take) begin
			phase_d  = phase_c;
			width_d  = width_c;
			height_d = height_c;
			unique case (phase_c)
				PH_HEADER: begin
					hdr_pos_d = pos_c + 5'd1;
					unique case (pos_c)
						5'd0:  id_len_d = b;
						5'd2:  rle_d = (b == RLE_IMAGE_TYPE);
						5'd12: width_d = {width_c[15:8], b};
						5'd13: width_d = {b, width_c[7:0]};
						5'd14: height_d = {height_c[15:8], b};
						5'd15: height_d = {b, height_c[7:0]};
						5'd16: begin
							if (b == DEPTH_24 || b == DEPTH_32 || (b == DEPTH_16 && !rle_q))
								depth_d = b;
							else
								depth_d = 8'd0;
							area_d = {16'h0, width_c} * {16'h0, height_c};
						end
						5'd17: begin
							cmd_valid = 1'b1;
							cmd.last  = 1'b1;
							if (depth_q == 8'd0) begin
								phase_d  = PH_DONE;
								cmd.kind = KIND_ERROR;
							end else begin
								cmd.kind     = KIND_HEADER;
								cmd.channels = chan;
								pix_rem_d    = area_q;
								if (area_q == 32'd0) begin
									phase_d = PH_DONE;
								end else begin
									cmd.last = 1'b0;
									if (id_len_q != 8'd0) begin
										skip_d  = id_len_q;
										phase_d = PH_SKIP;
									end else begin
										phase_d     = rle_q ? PH_PACKET : PH_PIXEL;
										bip_d       = 2'd0;
										pix_bytes_d = 24'h0;
									end
								end
							end
						end
						default: ;
					endcase
				end
				PH_SKIP: begin
					skip_d = skip_q - 8'd1;
					if (skip_q == 8'd1) begin
						phase_d     = rle_q ? PH_PACKET : PH_PIXEL;
						bip_d       = 2'd0;
						pix_bytes_d = 24'h0;
					end
				end
				PH_PACKET: begin
					pkt_rep_d   = b[7];
					pkt_rem_d   = {1'b0, b[6:0]} + 8'd1;
					phase_d     = PH_PIXEL;
					bip_d       = 2'd0;
					pix_bytes_d = 24'h0;
				end
				PH_PIXEL: begin
					if (bip_next != need) begin
						bip_d = bip_next;
						pix_bytes_d = word[23:0];
					end else begin
						bip_d            = 2'd0;
						pix_bytes_d      = 24'h0;
						cmd_valid        = 1'b1;
						cmd.kind         = KIND_PIXEL;
						cmd.pix_word     = word;
						cmd.fmt16        = (depth_q == DEPTH_16);
						cmd.has_alpha    = (depth_q == DEPTH_32);
						cmd.repeat_count = rep;
						cmd.channels     = chan;
						cmd.last         = (rem_after == 32'd0);
						pkt_rem_d        = pkt_after;
						pix_rem_d        = rem_after;
						if (rle_q && pkt_after == 8'd0)
							phase_d = PH_PACKET;
						if (rem_after == 32'd0)
							phase_d = PH_DONE;
					end
				end
				PH_DONE: ;
				default: phase_d = PH_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_pos_q   <= '0;
			id_len_q    <= '0;
			rle_q       <= 1'b0;
			width_q     <= '0;
			height_q    <= '0;
			depth_q     <= '0;
			area_q      <= '0;
			skip_q      <= '0;
			pix_rem_q   <= '0;
			pkt_rem_q   <= '0;
			pkt_rep_q   <= 1'b0;
			bip_q       <= '0;
			pix_bytes_q <= '0;
		end else begin
			phase_q     <= phase_d;
			hdr_pos_q   <= hdr_pos_d;
			id_len_q    <= id_len_d;
			rle_q       <= rle_d;
			width_q     <= width_d;
			height_q    <= height_d;
			depth_q     <= depth_d;
			area_q      <= area_d;
			skip_q      <= skip_d;
			pix_rem_q   <= pix_rem_d;
			pkt_rem_q   <= pkt_rem_d;
			pkt_rep_q   <= pkt_rep_d;
			bip_q       <= bip_d;
			pix_bytes_q <= pix_bytes_d;
		end
	end

endmodule

>>> sv/tgadec_queue.sv
// ----------------------------------------------------------------------------
// tgadec_queue
// Small first-in first-out buffer of commands between parser and output stage.
// ----------------------------------------------------------------------------
module tgadec_queue import tgadec_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> sv/tgadec_back.sv
// ----------------------------------------------------------------------------
// tgadec_back
// Output stage: reorders pixel bytes to RGB(A), widens 5-5-5, holds the result.
// ----------------------------------------------------------------------------
module tgadec_back import tgadec_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  cmd_t         cmd,
	tgadec_out_if.source result_stream
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  channels;
		logic        last;
	} res_t;

	res_t res_q;
	res_t res_d;
	logic valid_q;

	assign cmd_ready = !valid_q || result_stream.ready;

	always_comb begin
		res_d.kind         = cmd.kind;
		res_d.repeat_count = cmd.repeat_count;
		res_d.image_width  = cmd.image_width;
		res_d.image_height = cmd.image_height;
		res_d.channels     = cmd.channels;
		res_d.last         = cmd.last;
		if (cmd.fmt16) begin
			res_d.blue  = {cmd.pix_word[4:0], 3'b000};
			res_d.green = {cmd.pix_word[9:5], 3'b000};
			res_d.red   = {cmd.pix_word[14:10], 3'b000};
			res_d.alpha = 8'h00;
		end else begin
			res_d.blue  = cmd.pix_word[7:0];
			res_d.green = cmd.pix_word[15:8];
			res_d.red   = cmd.pix_word[23:16];
			res_d.alpha = cmd.has_alpha ? cmd.pix_word[31:24] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd_ready)
			valid_q <= cmd_valid;
	end

	assign result_stream.valid        = valid_q;
	assign result_stream.kind         = res_q.kind;
	assign result_stream.red          = res_q.red;
	assign result_stream.green        = res_q.green;
	assign result_stream.blue         = res_q.blue;
	assign result_stream.alpha        = res_q.alpha;
	assign result_stream.repeat_count = res_q.repeat_count;
	assign result_stream.image_width  = res_q.image_width;
	assign result_stream.image_height = res_q.image_height;
	assign result_stream.channels     = res_q.channels;
	assign result_stream.last         = res_q.last;

endmodule

>>> sv/targa_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// targa_pixel_stream_decoder
// TGA file decoder: header, ID skip, raw and RLE truecolour pixels as runs.
// ----------------------------------------------------------------------------
//  channel        dir  payload                                   words
//  byte_stream    in   data_byte, file_start                     one file byte
//  result_stream  out  kind, red..alpha, repeat_count, size,     one result
//                      channels, last
//
//  One file byte per cycle while the queue has room; header, packet and pixel state
//  advance on each byte taken. A result passes the queue, then the output register.
//  The header result follows header byte 17; the width by height product is
//  registered on byte 16.
//  arst_n clears all parser state, empties the queue and drops the output valid.
//  A two-word queue parts the parser from the output register; byte_stream.ready
//  falls only while that queue is full.
module targa_pixel_stream_decoder import tgadec_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	tgadec_in_if.sink    byte_stream,
	tgadec_out_if.source result_stream
);

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	tgadec_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.cmd_valid   (push_valid),
		.cmd_ready   (push_ready),
		.cmd         (push_data)
	);

	tgadec_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tgadec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd_ready     (pop_ready),
		.cmd           (pop_data),
		.result_stream (result_stream)
	);

endmodule

>>> sv/tgadec_checker.sv
// ----------------------------------------------------------------------------
// tgadec_checker
// Port-level checks on the result stream of the TGA decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgadec_checker import tgadec_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  red,
	input logic [7:0]  alpha,
	input logic [7:0]  repeat_count,
	input logic [2:0]  channels,
	input logic        last
);

	logic pix_out;
	logic err_out;
	logic hdr_out;

	assign pix_out = out_valid && (kind == KIND_PIXEL);
	assign err_out = out_valid && (kind == KIND_ERROR);
	assign hdr_out = out_valid && (kind == KIND_HEADER);

	`ASSERT_SAME_CYCLE(a_pix_run, clk, arst_n, pix_out, repeat_count != 8'd0 && repeat_count <= 8'd128 && (channels == CHAN_RGB || channels == CHAN_RGBA), "pixel run length or channels out of range")
	`ASSERT_SAME_CYCLE(a_err_fields, clk, arst_n, err_out, last && channels == 3'd0 && repeat_count == 8'd0 && red == 8'd0, "error result fields wrong")
	`ASSERT_SAME_CYCLE(a_hdr_fields, clk, arst_n, hdr_out, repeat_count == 8'd0 && red == 8'd0 && (channels == CHAN_RGB || channels == CHAN_RGBA), "header result fields wrong")
	`ASSERT_SAME_CYCLE(a_rgb_alpha, clk, arst_n, out_valid && channels == CHAN_RGB, alpha == 8'd0, "alpha set on a three-channel result")
	`ASSERT_NEXT_CYCLE(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(repeat_count) && $stable(last), "stalled result changed")

endmodule

bind targa_pixel_stream_decoder tgadec_checker u_tgadec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_stream.valid),
	.out_ready    (result_stream.ready),
	.kind         (result_stream.kind),
	.red          (result_stream.red),
	.alpha        (result_stream.alpha),
	.repeat_count (result_stream.repeat_count),
	.channels     (result_stream.channels),
	.last         (result_stream.last)
);

>>> tb/targa_pixel_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// targa_pixel_stream_decoder_tb
// Streams TGA files through the decoder a byte at a time and checks every
// result. A directed table of files covers the header cases, every pixel
// format and the clipping rules. Random files follow: raw and run-length
// bodies, ID fields, odd depths, truncated files and trailing junk. A
// behavioural decoder predicts each result, the directed table pins its own
// header words, and the sender and receiver both stall at random.
// ----------------------------------------------------------------------------
module targa_pixel_stream_decoder_tb;
	import tgadec_pkg::*;

	localparam int HEADER_BYTES  = 18;
	localparam int HB_ID_LENGTH  = 0;
	localparam int HB_IMAGE_TYPE = 2;
	localparam int HB_WIDTH_LO   = 12;
	localparam int HB_WIDTH_HI   = 13;
	localparam int HB_HEIGHT_LO  = 14;
	localparam int HB_HEIGHT_HI  = 15;
	localparam int HB_DEPTH      = 16;
	localparam int HB_CLOSE      = 17;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_BYTES  = 1150;
	localparam int SETTLE_CYCLES = 24;

	typedef enum logic [2:0] {
		ST_HEADER, ST_SKIP, ST_PACKET, ST_PIXEL, ST_DONE
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_count;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  channels;
		logic        last;
	} decoded_t;

	// One directed file: header fields, the bytes after the ID field (read left
	// to right from the literal) and the header or error word it must give
	typedef struct packed {
		logic         fs;
		logic [7:0]   id_len;
		logic [7:0]   img_type;
		logic [7:0]   fill;
		logic [7:0]   depth;
		logic [15:0]  w;
		logic [15:0]  h;
		logic [4:0]   n_payload;
		logic [127:0] payload;
		logic [1:0]   hdr_kind;
		logic [2:0]   hdr_ch;
		logic         hdr_last;
	} file_row_t;

	logic clk;
	logic arst_n;

	tgadec_in_if  byte_if();
	tgadec_out_if result_if();

	targa_pixel_stream_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_if),
		.result_stream(result_if)
	);

	// Behavioural decoder state
	parse_state_t dec_phase;
	logic [4:0]   hdr_pos;
	logic [7:0]   id_len_r;
	logic         rle_mode;
	logic [15:0]  width_r;
	logic [15:0]  height_r;
	logic [5:0]   depth_r;
	logic [8:0]   skip_left;
	logic [31:0]  pix_left;
	logic [7:0]   pkt_left;
	logic         pkt_repeat;
	logic [1:0]   pix_idx;
	logic [31:0]  pix_word;

	decoded_t    expected_q[$];
	logic        cur_pin;
	decoded_t    cur_pin_res;
	int          burst_left;
	int          gap_left;
	int          sink_mode;
	int          sink_cycle;
	int          hold_left;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned files_sent;
	int unsigned bytes_sent;
	int unsigned stream_bytes;
	int unsigned n_headers;
	int unsigned n_pixels;
	int unsigned n_errors;
	file_row_t   dir_files [10];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic clear_decoder();
		dec_phase  = ST_HEADER;
		hdr_pos    = '0;
		id_len_r   = '0;
		rle_mode   = 1'b0;
		width_r    = '0;
		height_r   = '0;
		depth_r    = '0;
		skip_left  = '0;
		pix_left   = '0;
		pkt_left   = '0;
		pkt_repeat = 1'b0;
		pix_idx    = '0;
		pix_word   = '0;
	endtask

	task automatic enter_pixels();
		dec_phase = rle_mode ? ST_PACKET : ST_PIXEL;
		pix_idx   = '0;
		pix_word  = '0;
	endtask

	function automatic decoded_t make_result(input logic [1:0] kind, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
			input logic [7:0] rep, input logic [2:0] ch, input logic last);
		decoded_t res;
		res.kind         = kind;
		res.red          = r;
		res.green        = g;
		res.blue         = b;
		res.alpha        = a;
		res.repeat_count = rep;
		res.image_width  = width_r;
		res.image_height = height_r;
		res.channels     = ch;
		res.last         = last;
		return res;
	endfunction

	// Advance the decoder by one file byte; got is set when the byte closes a result
	task automatic decode_byte(input logic [7:0] b, input logic fs, output logic got,
			output decoded_t res);
		logic [4:0]  pos;
		logic [2:0]  need;
		logic [2:0]  ch;
		logic [15:0] v;
		logic [7:0]  rr, gg, bb, aa;
		logic [31:0] run_len;
		got = 1'b0;
		res = '0;
		if (fs)
			clear_decoder();
		ch = (depth_r == 6'(DEPTH_32)) ? CHAN_RGBA : CHAN_RGB;
		case (dec_phase)
		ST_HEADER: begin
			pos     = hdr_pos;
			hdr_pos = pos + 5'd1;
			case (int'(pos))
			HB_ID_LENGTH:  id_len_r = b;
			HB_IMAGE_TYPE: rle_mode = (b == RLE_IMAGE_TYPE);
			HB_WIDTH_LO:   width_r[7:0] = b;
			HB_WIDTH_HI:   width_r[15:8] = b;
			HB_HEIGHT_LO:  height_r[7:0] = b;
			HB_HEIGHT_HI:  height_r[15:8] = b;
			HB_DEPTH: begin
				if (b == DEPTH_24 || b == DEPTH_32 || (b == DEPTH_16 && !rle_mode))
					depth_r = b[5:0];
				else
					depth_r = '0;
			end
			HB_CLOSE: begin
				got = 1'b1;
				if (depth_r == '0) begin
					dec_phase = ST_DONE;
					res = make_result(KIND_ERROR, 0, 0, 0, 0, 0, 3'd0, 1'b1);
				end else begin
					pix_left = 32'(width_r) * 32'(height_r);
					ch = (depth_r == 6'(DEPTH_32)) ? CHAN_RGBA : CHAN_RGB;
					if (pix_left == 0) begin
						dec_phase = ST_DONE;
						res = make_result(KIND_HEADER, 0, 0, 0, 0, 0, ch, 1'b1);
					end else begin
						if (id_len_r != 0) begin
							skip_left = 9'(id_len_r);
							dec_phase = ST_SKIP;
						end else begin
							enter_pixels();
						end
						res = make_result(KIND_HEADER, 0, 0, 0, 0, 0, ch, 1'b0);
					end
				end
			end
			default: ;
			endcase
		end
		ST_SKIP: begin
			if (skip_left > 0)
				skip_left = skip_left - 9'd1;
			if (skip_left == 0)
				enter_pixels();
		end
		ST_PACKET: begin
			if (b < 8'd128) begin
				pkt_left   = b + 8'd1;
				pkt_repeat = 1'b0;
			end else begin
				pkt_left   = b - 8'd127;
				pkt_repeat = 1'b1;
			end
			dec_phase = ST_PIXEL;
			pix_idx   = '0;
			pix_word  = '0;
		end
		ST_PIXEL: begin
			pix_word = pix_word | (32'(b) << (8 * pix_idx));
			pix_idx  = pix_idx + 2'd1;
			need     = 3'(depth_r >> 3);
			if (pix_idx == need[1:0]) begin
				if (depth_r == 6'(DEPTH_16)) begin
					v  = pix_word[15:0];
					bb = {v[4:0], 3'b000};
					gg = {v[9:5], 3'b000};
					rr = {v[14:10], 3'b000};
					aa = 8'd0;
				end else begin
					bb = pix_word[7:0];
					gg = pix_word[15:8];
					rr = pix_word[23:16];
					aa = (depth_r == 6'(DEPTH_32)) ? pix_word[31:24] : 8'd0;
				end
				pix_idx  = '0;
				pix_word = '0;
				run_len  = 32'd1;
				if (rle_mode) begin
					if (pkt_repeat) begin
						run_len = 32'(pkt_left);
						if (run_len > pix_left)
							run_len = pix_left;
						pkt_left = '0;
					end else if (pkt_left > 0) begin
						pkt_left = pkt_left - 8'd1;
					end
					if (pkt_left == 0)
						dec_phase = ST_PACKET;
				end
				pix_left = pix_left - run_len;
				if (pix_left == 0)
					dec_phase = ST_DONE;
				got = 1'b1;
				res = make_result(KIND_PIXEL, rr, gg, bb, aa, run_len[7:0], ch, pix_left == 0);
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned seen);
		if (want != seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			mismatches++;
		end
	endtask

	// Check each result word against the oldest expectation, then predict from the
	// byte taken at this edge
	always @(posedge clk) begin : scoreboard
		decoded_t seen;
		decoded_t want;
		decoded_t pred;
		logic     got;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				seen.kind         = result_if.kind;
				seen.red          = result_if.red;
				seen.green        = result_if.green;
				seen.blue         = result_if.blue;
				seen.alpha        = result_if.alpha;
				seen.repeat_count = result_if.repeat_count;
				seen.image_width  = result_if.image_width;
				seen.image_height = result_if.image_height;
				seen.channels     = result_if.channels;
				seen.last         = result_if.last;
				case (seen.kind)
				KIND_HEADER: n_headers++;
				KIND_PIXEL:  n_pixels++;
				default:     n_errors++;
				endcase
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: kind %0d", seen.kind);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("kind", want.kind, seen.kind);
					check_field("red", want.red, seen.red);
					check_field("green", want.green, seen.green);
					check_field("blue", want.blue, seen.blue);
					check_field("alpha", want.alpha, seen.alpha);
					check_field("repeat_count", want.repeat_count, seen.repeat_count);
					check_field("image_width", want.image_width, seen.image_width);
					check_field("image_height", want.image_height, seen.image_height);
					check_field("channels", want.channels, seen.channels);
					check_field("last", want.last, seen.last);
				end
			end
			if (byte_if.valid && byte_if.ready) begin
				decode_byte(byte_if.data_byte, byte_if.file_start, got, pred);
				if (cur_pin) begin
					pred = cur_pin_res;
					got  = 1'b1;
				end
				if (got)
					expected_q.push_back(pred);
			end
		end
	end

	// Receiver: switch between free flow, coin-toss ready and long stalls
	always @(negedge clk) begin
		if (sink_cycle == 0) begin
			sink_mode  = $urandom_range(0, 2);
			sink_cycle = $urandom_range(50, 300);
		end else begin
			sink_cycle--;
		end
		case (sink_mode)
		0: result_if.ready <= 1'b1;
		1: result_if.ready <= 1'($urandom_range(0, 1));
		default: begin
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(1, 12);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_q.size());
			$display("FAIL targa_pixel_stream_decoder");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_byte(input logic [7:0] b, input logic fs, input logic pin,
			input decoded_t pin_res);
		if (gap_left > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap_left) @(negedge clk);
			gap_left = 0;
		end
		byte_if.valid      <= 1'b1;
		byte_if.data_byte  <= b;
		byte_if.file_start <= fs;
		cur_pin     = pin;
		cur_pin_res = pin_res;
		do
			@(posedge clk);
		while (!byte_if.ready);
		bytes_sent++;
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		@(negedge clk);
	endtask

	task automatic send_header(input logic fs, input logic [7:0] id_len,
			input logic [7:0] img_type, input logic [7:0] fill, input logic [7:0] depth,
			input logic [15:0] w, input logic [15:0] h, input logic pin,
			input decoded_t pin_res);
		logic [7:0] hb;
		for (int pos = 0; pos < HEADER_BYTES; pos++) begin
			case (pos)
			HB_ID_LENGTH:  hb = id_len;
			HB_IMAGE_TYPE: hb = img_type;
			HB_WIDTH_LO:   hb = w[7:0];
			HB_WIDTH_HI:   hb = w[15:8];
			HB_HEIGHT_LO:  hb = h[7:0];
			HB_HEIGHT_HI:  hb = h[15:8];
			HB_DEPTH:      hb = depth;
			default:       hb = fill;
			endcase
			send_byte(hb, (pos == HB_ID_LENGTH) ? fs : 1'b0, pin && pos == HB_CLOSE, pin_res);
		end
		for (int i = 0; i < int'(id_len); i++)
			send_byte(rand_byte(), 1'b0, 1'b0, '0);
		files_sent++;
	endtask

	// Hold the sender until every expected word has come out
	task automatic hold_until_drained();
		byte_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_file();
		logic        rle;
		logic        fs;
		logic        fmt_ok;
		logic [7:0]  img_type;
		logic [7:0]  depth;
		logic [7:0]  id_len;
		logic [15:0] w;
		logic [15:0] h;
		int unsigned px_total;
		int unsigned px_left;
		int unsigned bpp;
		int unsigned run;
		int unsigned shown;
		int unsigned cut;
		int unsigned sel;
		logic [7:0]  body[$];
		rle = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
		0: img_type = 8'd2;
		1: img_type = 8'd3;
		2: img_type = 8'd0;
		default: img_type = 8'($urandom_range(11, 255));
		endcase
		if (rle)
			img_type = RLE_IMAGE_TYPE;
		case ($urandom_range(0, 9))
		0: depth = rle ? DEPTH_16 : 8'($urandom_range(0, 15));
		1: depth = 8'($urandom);
		default: begin
			if (rle)
				depth = $urandom_range(0, 1) ? DEPTH_24 : DEPTH_32;
			else
				case ($urandom_range(0, 2))
				0: depth = DEPTH_16;
				1: depth = DEPTH_24;
				default: depth = DEPTH_32;
				endcase
		end
		endcase
		sel = $urandom_range(0, 99);
		if (sel < 65)
			id_len = 8'd0;
		else if (sel < 97)
			id_len = 8'($urandom_range(1, 6));
		else
			id_len = 8'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 6) begin
			w = 16'($urandom);
			h = 16'($urandom);
			if ($urandom_range(0, 1))
				w = '0;
			else
				h = '0;
		end else if (sel < 11) begin
			w = 16'($urandom);
			h = 16'($urandom);
		end else begin
			w = 16'($urandom_range(1, 4));
			h = 16'($urandom_range(1, 3));
		end
		fs = ($urandom_range(0, 19) != 0);
		send_header(fs, id_len, img_type, rand_byte(), depth, w, h, 1'b0, '0);

		fmt_ok = (depth == DEPTH_24 || depth == DEPTH_32 || (depth == DEPTH_16 && !rle));
		bpp = int'(depth) / 8;
		px_total = 32'(w) * 32'(h);
		px_left = (px_total > 16) ? $urandom_range(1, 8) : px_total;
		if (!fmt_ok) begin
			repeat ($urandom_range(0, 3)) body.push_back(rand_byte());
		end else if (!rle) begin
			repeat (px_left * bpp) body.push_back(rand_byte());
		end else begin
			while (px_left > 0) begin
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
				if ($urandom_range(0, 1)) begin
					body.push_back(8'(127 + run));
					repeat (bpp) body.push_back(rand_byte());
				end else begin
					body.push_back(8'(run - 1));
					shown = (run < px_left) ? run : px_left;
					repeat (shown * bpp) body.push_back(rand_byte());
				end
				px_left = (run < px_left) ? px_left - run : 0;
			end
		end
		// Broken file: cut the body short, the next file_start restarts parsing
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(0, body.size());
			while (body.size() > cut)
				void'(body.pop_back());
		end
		if (fs)
			stream_bytes += HEADER_BYTES + int'(id_len) + body.size();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) body.push_back(rand_byte());
		foreach (body[i])
			send_byte(body[i], 1'b0, 1'b0, '0);
	endtask

	initial begin
		file_row_t row;
		decoded_t  hdr_pin;
		int        file_no;
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		byte_if.file_start = 1'b0;
		result_if.ready = 1'b0;
		cur_pin = 1'b0;
		cur_pin_res = '0;
		burst_left = 0;
		gap_left = 0;
		sink_mode = 0;
		sink_cycle = 0;
		hold_left = 0;
		cycle_count = 0;
		mismatches = 0;
		files_sent = 0;
		bytes_sent = 0;
		stream_bytes = 0;
		n_headers = 0;
		n_pixels = 0;
		n_errors = 0;
		clear_decoder();

		//            fs     id     type   fill   depth  w         h         n
		dir_files = '{
			// first file straight after reset, no file_start, ID field and junk after
			'{1'b0, 8'd2, 8'd2, 8'h00, DEPTH_24, 16'd2, 16'd1, 5'd8,
				128'h112233_445566_A5A5, KIND_HEADER, CHAN_RGB, 1'b0},
			'{1'b1, 8'd0, 8'd2, 8'h00, DEPTH_32, 16'd1, 16'd1, 5'd4,
				128'hFFFFFFFF, KIND_HEADER, CHAN_RGBA, 1'b0},
			// 5-5-5 with every colour bit set, then only the unused top bit
			'{1'b1, 8'd0, 8'd2, 8'h00, DEPTH_16, 16'd2, 16'd1, 5'd4,
				128'hFF7F_0080, KIND_HEADER, CHAN_RGB, 1'b0},
			// longest repeat packet clipped to three pixels
			'{1'b1, 8'd0, RLE_IMAGE_TYPE, 8'h00, DEPTH_24, 16'd3, 16'd1, 5'd4,
				128'hFF_0A0B0C, KIND_HEADER, CHAN_RGB, 1'b0},
			// longest raw packet stops when the image is complete
			'{1'b1, 8'd0, RLE_IMAGE_TYPE, 8'h00, DEPTH_32, 16'd2, 16'd1, 5'd11,
				128'h7F_01020304_F0E0D0C0_5555, KIND_HEADER, CHAN_RGBA, 1'b0},
			// run-length 16-bit is not supported
			'{1'b1, 8'd0, RLE_IMAGE_TYPE, 8'h00, DEPTH_16, 16'd4, 16'd4, 5'd1,
				128'h00, KIND_ERROR, 3'd0, 1'b1},
			'{1'b1, 8'd0, 8'd2, 8'h00, 8'd8, 16'd1, 16'd1, 5'd3,
				128'h123456, KIND_ERROR, 3'd0, 1'b1},
			// empty image completes on its header
			'{1'b1, 8'd0, 8'd2, 8'h00, DEPTH_24, 16'hFFFF, 16'd0, 5'd2,
				128'h7777, KIND_HEADER, CHAN_RGB, 1'b1},
			// largest ID field and size, cut short by the next file
			'{1'b1, 8'd255, RLE_IMAGE_TYPE, 8'hFF, DEPTH_24, 16'hFFFF, 16'hFFFF, 5'd8,
				128'h80_112233_00_445566, KIND_HEADER, CHAN_RGB, 1'b0},
			// colour-mapped type with busy colour map fields, read as raw
			'{1'b1, 8'd0, 8'd1, 8'h5A, DEPTH_24, 16'd1, 16'd1, 5'd3,
				128'hC0FFEE, KIND_HEADER, CHAN_RGB, 1'b0}
		};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_files[i]) begin
			row = dir_files[i];
			hdr_pin = '0;
			hdr_pin.kind = row.hdr_kind;
			hdr_pin.image_width = row.w;
			hdr_pin.image_height = row.h;
			hdr_pin.channels = row.hdr_ch;
			hdr_pin.last = row.hdr_last;
			send_header(row.fs, row.id_len, row.img_type, row.fill, row.depth, row.w, row.h,
				1'b1, hdr_pin);
			for (int k = 0; k < int'(row.n_payload); k++)
				send_byte(row.payload[8 * (int'(row.n_payload) - 1 - k) +: 8], 1'b0, 1'b0, '0);
		end

		file_no = 0;
		while (stream_bytes < RANDOM_BYTES) begin
			send_random_file();
			if (file_no % 12 == 4)
				hold_until_drained();
			file_no++;
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			mismatches++;
		end
		$display("%0d files, %0d bytes in; %0d headers, %0d pixel runs, %0d format errors out",
			files_sent, bytes_sent, n_headers, n_pixels, n_errors);
		$display("%0d field mismatches over %0d cycles", mismatches, cycle_count);
		if (mismatches == 0)
			$display("PASS targa_pixel_stream_decoder");
		else
			$display("FAIL targa_pixel_stream_decoder");
		$finish;
	end

endmodule
